FILE: rtl/ttsf_pkg.sv
// Package for the temperature to seven-segment frame block.
// Holds scaling constants, the digit bundle type and segment/enable lookups.
// No dependencies.
package ttsf_pkg;

    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned PROD_W    = 19;   // 1023*500 = 511500 < 2**19
    localparam int unsigned VALUE_W   = 9;    // degree value tops out at 500
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned ENABLE_W  = 4;
    localparam int unsigned SEG_W     = 8;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W     = 2;

    localparam logic [PROD_W-1:0]  SCALE_NUM = PROD_W'(500);
    localparam logic [PROD_W-1:0]  SCALE_DEN = PROD_W'(1023);

    // Word positions within one frame, thousands first
    localparam logic [IDX_W-1:0] POS_THOU  = 2'd0;
    localparam logic [IDX_W-1:0] POS_HUND  = 2'd1;
    localparam logic [IDX_W-1:0] POS_TENS  = 2'd2;
    localparam logic [IDX_W-1:0] POS_UNITS = 2'd3;

    // Active-low digit enables
    localparam logic [ENABLE_W-1:0] EN_THOU  = 4'b1110;
    localparam logic [ENABLE_W-1:0] EN_HUND  = 4'b1101;
    localparam logic [ENABLE_W-1:0] EN_TENS  = 4'b1011;
    localparam logic [ENABLE_W-1:0] EN_UNITS = 4'b0111;

    typedef struct packed {
        logic [DIGIT_W-1:0] thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } digits_t;

    // Common-cathode pattern, bit0 = segment a .. bit6 = segment g
    function automatic logic [SEG_W-1:0] seg_lut(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h6F;   // non-decimal codes show as nine
        endcase
        return s;
    endfunction

    function automatic logic [ENABLE_W-1:0] enable_lut(input logic [IDX_W-1:0] pos);
        logic [ENABLE_W-1:0] e;
        unique case (pos)
            POS_THOU:  e = EN_THOU;
            POS_HUND:  e = EN_HUND;
            POS_TENS:  e = EN_TENS;
            POS_UNITS: e = EN_UNITS;
            default:   e = EN_UNITS;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/ttsf_sample_if.sv
// Input channel: one raw converter sample per item.
// Depends on ttsf_pkg.
interface ttsf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [ttsf_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

FILE: rtl/ttsf_frame_if.sv
// Output channel: one display word (digit enable, segments, last flag) per item.
// Depends on ttsf_pkg.
interface ttsf_frame_if;
    logic                          valid;
    logic                          ready;
    logic [ttsf_pkg::ENABLE_W-1:0] digit_enable;
    logic [ttsf_pkg::SEG_W-1:0]    segment_pattern;
    logic                          last_digit;

    modport source (output valid, output digit_enable, output segment_pattern,
                    output last_digit, input ready);
    modport sink   (input valid, input digit_enable, input segment_pattern,
                    input last_digit, output ready);
endinterface

FILE: rtl/temperature_to_seven_segment_frames_top.sv
// Top level: converter sample in, four seven-segment display words out.
// Depends on ttsf_pkg, ttsf_sample_if, ttsf_frame_if, ttsf_digit_pipe, ttsf_frame_ser.
//
//  Channel     Dir  Payload                                       Per item
//  sample_in   in   adc_sample[9:0]                               one sample
//  frame_out   out  digit_enable[3:0], segment_pattern[7:0],      one word, four per sample
//                   last_digit
//
// A sample passes four register stages (multiply, reciprocal estimate, correction,
// hundreds split) and then the serializer, which registers its four patterns before the
// first word is offered. The serializer sends one word a cycle while frame_out is ready,
// and takes the next sample as the units word leaves; up to five samples are in flight.
// Reset clears all valid bits and the serializer; a stall on frame_out freezes the
// pipeline without losing any item.
module temperature_to_seven_segment_frames_top (
    input  logic   clk,
    input  logic   rst_n,
    ttsf_sample_if.sink  sample_in,
    ttsf_frame_if.source frame_out
);
    import ttsf_pkg::*;

    logic    pipe_valid;
    logic    pipe_ready;
    digits_t pipe_digits;

    ttsf_digit_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_in.valid),
        .in_ready   (sample_in.ready),
        .in_sample  (sample_in.adc_sample),
        .out_valid  (pipe_valid),
        .out_ready  (pipe_ready),
        .out_digits (pipe_digits)
    );

    ttsf_frame_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pipe_valid),
        .in_ready     (pipe_ready),
        .in_digits    (pipe_digits),
        .out_valid    (frame_out.valid),
        .out_ready    (frame_out.ready),
        .out_enable   (frame_out.digit_enable),
        .out_segments (frame_out.segment_pattern),
        .out_last     (frame_out.last_digit)
    );

endmodule

FILE: rtl/ttsf_digit_pipe.sv
// Four-stage pipeline: scale sample to degrees, divide by 1023, split digits.
// Depends on ttsf_pkg.
module ttsf_digit_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttsf_pkg::SAMPLE_W-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ttsf_pkg::digits_t             out_digits
);
    import ttsf_pkg::*;

    logic                 adv;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PROD_W-1:0]    prod1_reg, prod2_reg;
    logic [VALUE_W-1:0]   qest2_reg;
    logic [VALUE_W-1:0]   value3_reg;
    logic [DIGIT_W-1:0]   hund4_reg;
    logic [6:0]           rem4_reg;

    logic [PROD_W-1:0]    prod1_next;
    logic [29:0]          recip_sum;
    logic [VALUE_W-1:0]   qest2_next;
    logic [PROD_W-1:0]    qx_den;
    logic [PROD_W-1:0]    resid;
    logic [VALUE_W-1:0]   value3_next;
    logic [DIGIT_W-1:0]   hund4_next;
    logic [6:0]           rem4_next;
    logic [DIGIT_W-1:0]   tens_d;
    logic [6:0]           tens_x10;
    logic [6:0]           units_wide;

    // Advance every stage together unless the last stage holds an untaken item
    assign adv      = !v4_reg || out_ready;
    assign in_ready = adv;

    // Stage 1: multiply by 500
    assign prod1_next = PROD_W'(in_sample) * SCALE_NUM;

    // Stage 2: estimate p/1023 as p*1025/2**20, never above the true quotient
    assign recip_sum  = 30'(prod1_reg) + {1'b0, prod1_reg, 10'b0};
    assign qest2_next = recip_sum[28:20];

    // Stage 3: correct the estimate by at most one; the result never exceeds
    // 500, so the 9999 display limit cannot be hit and needs no clamp
    assign qx_den      = {qest2_reg, 10'b0} - PROD_W'(qest2_reg);
    assign resid       = prod2_reg - qx_den;
    assign value3_next = (resid >= SCALE_DEN) ? qest2_reg + VALUE_W'(1) : qest2_reg;

    // Stage 4: hundreds digit and remainder below one hundred
    always_comb
    begin
        priority if (value3_reg >= VALUE_W'(500))
        begin
            hund4_next = 4'd5;
            rem4_next  = 7'(value3_reg - VALUE_W'(500));
        end
        else if (value3_reg >= VALUE_W'(400))
        begin
            hund4_next = 4'd4;
            rem4_next  = 7'(value3_reg - VALUE_W'(400));
        end
        else if (value3_reg >= VALUE_W'(300))
        begin
            hund4_next = 4'd3;
            rem4_next  = 7'(value3_reg - VALUE_W'(300));
        end
        else if (value3_reg >= VALUE_W'(200))
        begin
            hund4_next = 4'd2;
            rem4_next  = 7'(value3_reg - VALUE_W'(200));
        end
        else if (value3_reg >= VALUE_W'(100))
        begin
            hund4_next = 4'd1;
            rem4_next  = 7'(value3_reg - VALUE_W'(100));
        end
        else
        begin
            hund4_next = 4'd0;
            rem4_next  = 7'(value3_reg);
        end
    end

    // Tens and units from the stage-4 remainder
    always_comb
    begin
        priority if (rem4_reg >= 7'd90) tens_d = 4'd9;
        else if (rem4_reg >= 7'd80)     tens_d = 4'd8;
        else if (rem4_reg >= 7'd70)     tens_d = 4'd7;
        else if (rem4_reg >= 7'd60)     tens_d = 4'd6;
        else if (rem4_reg >= 7'd50)     tens_d = 4'd5;
        else if (rem4_reg >= 7'd40)     tens_d = 4'd4;
        else if (rem4_reg >= 7'd30)     tens_d = 4'd3;
        else if (rem4_reg >= 7'd20)     tens_d = 4'd2;
        else if (rem4_reg >= 7'd10)     tens_d = 4'd1;
        else                            tens_d = 4'd0;
    end

    assign tens_x10   = {tens_d, 3'b000} + {2'b00, tens_d, 1'b0};
    assign units_wide = rem4_reg - tens_x10;

    assign out_valid        = v4_reg;
    assign out_digits.thou  = '0;
    assign out_digits.hund  = hund4_reg;
    assign out_digits.tens  = tens_d;
    assign out_digits.units = units_wide[DIGIT_W-1:0];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg  <= prod1_next;
            prod2_reg  <= prod1_reg;
            qest2_reg  <= qest2_next;
            value3_reg <= value3_next;
            hund4_reg  <= hund4_next;
            rem4_reg   <= rem4_next;
        end
    end

    // A stalled last stage keeps its item
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !out_ready) |=> (v4_reg && $stable(hund4_reg) && $stable(rem4_reg)))
        else $error("stalled item changed in last stage");

    // Corrected quotient stays in the scaled range
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (value3_reg <= VALUE_W'(500)))
        else $error("degree value out of range");

    // Remainder is a two-digit value
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (rem4_reg < 7'd100 && units_wide < 7'd10))
        else $error("digit split remainder out of range");

endmodule

FILE: rtl/ttsf_frame_ser.sv
// Frame serializer: holds four segment patterns and sends them one word a cycle while the output is ready.
// Depends on ttsf_pkg.
module ttsf_frame_ser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ttsf_pkg::digits_t             in_digits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttsf_pkg::ENABLE_W-1:0] out_enable,
    output logic [ttsf_pkg::SEG_W-1:0]    out_segments,
    output logic                          out_last
);
    import ttsf_pkg::*;

    logic                 busy_reg, busy_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SEG_W-1:0]     seg_reg [NUM_WORDS];
    logic                 take;
    logic                 load;

    // Take a new frame when empty or as the units word leaves
    assign take     = !busy_reg || (out_ready && idx_reg == POS_UNITS);
    assign load     = take && in_valid;
    assign in_ready = take;

    assign out_valid    = busy_reg;
    assign out_enable   = enable_lut(idx_reg);
    assign out_segments = seg_reg[idx_reg];
    assign out_last     = (idx_reg == POS_UNITS);

    // Next word position and occupancy
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        priority if (load)
        begin
            busy_next = 1'b1;
            idx_next  = POS_THOU;
        end
        else if (take)
        begin
            busy_next = 1'b0;
            idx_next  = POS_THOU;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= POS_THOU;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Load the four patterns of a frame
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg[POS_THOU]  <= seg_lut(in_digits.thou);
            seg_reg[POS_HUND]  <= seg_lut(in_digits.hund);
            seg_reg[POS_TENS]  <= seg_lut(in_digits.tens);
            seg_reg[POS_UNITS] <= seg_lut(in_digits.units);
        end
    end

    // Word position only moves while a frame is held
    a_idx_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != POS_THOU) |-> busy_reg)
        else $error("word position set with no frame held");

    // A sent non-final word steps to the next position
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_ready && idx_reg != POS_UNITS) |=> (idx_reg == $past(idx_reg) + IDX_W'(1)))
        else $error("word position did not advance");

    // A new frame always starts at the thousands word
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == POS_THOU))
        else $error("frame did not start at thousands word");

endmodule
